// File: src/fca_pkg.sv
// shared types, constants and codes of the first-fit chunk allocator
package fca_pkg;

   localparam int SLOTS       = 64;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int OFF_W       = 20;
   localparam int LEN_W       = 21;
   localparam int POS_W       = 22;
   localparam int ADDR_W      = 48;
   localparam int PAGE_W      = 9;
   localparam int PAGE_SHIFT  = 12;
   localparam int HEAP_PAGES  = 256;
   localparam int ALIGN_SHIFT = 5;
   localparam int ALIGN_BYTES = 1 << ALIGN_SHIFT;

   localparam logic [LEN_W-1:0]  PAGE_LEN   = LEN_W'(1 << PAGE_SHIFT);
   localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(HEAP_PAGES);

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_BAD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO     = 2'd1,
      ST_NOMEM    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      CSR_HEAP_BASE = 1'b0,
      CSR_MAX_PAGES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [LEN_W-1:0]  req_size;
      logic [ADDR_W-1:0] req_address;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] chunk_address;
      logic [LEN_W-1:0]  chunk_size;
   } rsp_word_type;

   typedef struct packed {
      logic             free;
      logic [LEN_W-1:0] len;
      logic [OFF_W-1:0] off;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // kind of table scan in progress
   typedef enum logic [2:0] {
      SCAN_FIT,
      SCAN_END,
      SCAN_PLACE,
      SCAN_ADDR,
      SCAN_RIGHT,
      SCAN_LEFT
   } scan_kind_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SET_STATUS,
      OP_SCAN_INIT,
      OP_SCAN_INC,
      OP_HIT_FIT,
      OP_WRITE_ALLOC,
      OP_GROW_SET,
      OP_GROW_EXTEND,
      OP_PAGES_INC,
      OP_PLACE_EMPTY,
      OP_PLACE_MERGE,
      OP_PLACE_NEW,
      OP_FOUND,
      OP_RESP_QUERY,
      OP_RIGHT_MERGE,
      OP_LEFT_MERGE,
      OP_WRITE_FREE,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type     op;
      scan_kind_type kind;
      status_type    status;
   } dp_cmd_type;

   typedef struct packed {
      logic       hit;
      logic       empty;
      logic       last;
      logic       split;
      logic       at_limit;
      logic       table_full;
      logic       hit_is_c;
      logic       size_zero;
      logic [1:0] cmd;
      logic       rsp_free;
   } dp_stat_type;

endpackage

// File: src/fca_ram.sv
// generic single-port-write ram with registered read
module fca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fca_dp.sv
// datapath: slot table, counters, config registers and result word
module fca_dp
   import fca_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd_in,
   input  req_word_type         req_data,
   output dp_stat_type          stat,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_data
);

   // request and work registers
   logic [1:0]        cmd_ff;
   logic [POS_W-1:0]  want_ff;
   logic [ADDR_W-1:0] rel_ff;
   logic              size_zero_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  h_idx_ff;
   logic [OFF_W-1:0]  h_off_ff;
   logic [LEN_W-1:0]  h_len_ff;
   logic [POS_W-1:0]  p_off_ff;
   logic [LEN_W-1:0]  p_len_ff;
   logic [IDX_W-1:0]  c_idx_ff;
   logic [OFF_W-1:0]  c_off_ff;
   logic [LEN_W-1:0]  c_len_ff;
   logic [CNT_W-1:0]  slots_ff;
   logic [PAGE_W-1:0] pages_ff;
   logic [ADDR_W-1:0] heap_base_ff;
   logic [PAGE_W-1:0] max_pages_ff;
   logic [SLOTS-1:0]  slot_valid_ff;
   logic              rd_valid_ff;
   logic              rd_first_ff;
   rsp_word_type      res_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_data_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_entry_type    wr_data;
   logic [ENTRY_W-1:0] ram_q;
   slot_entry_type    ram_entry;
   slot_entry_type    entry;
   logic [POS_W-1:0]  e_end;
   logic [POS_W-1:0]  c_end;
   logic [POS_W-1:0]  want_in;
   logic [PAGE_W-1:0] lim;
   logic              hit;

   fca_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(ram_q)
   );

   // entry never written reads as its reset value
   always_comb begin
      ram_entry = slot_entry_type'(ram_q);
      if (rd_valid_ff) begin
         entry = ram_entry;
      end else if (rd_first_ff) begin
         entry = '{free: 1'b1, len: PAGE_LEN, off: '0};
      end else begin
         entry = '0;
      end
   end

   assign e_end = POS_W'(entry.off) + POS_W'(entry.len);
   assign c_end = POS_W'(c_off_ff) + POS_W'(c_len_ff);
   assign want_in = (POS_W'(req_data.req_size) + POS_W'(ALIGN_BYTES - 1))
                    & ~POS_W'(ALIGN_BYTES - 1);
   assign lim = (max_pages_ff > PAGE_LIMIT) ? PAGE_LIMIT : max_pages_ff;

   // match test of the current entry for each scan kind
   always_comb begin
      case (cmd_in.kind)
         SCAN_FIT:   hit = entry.free && (entry.len != '0) && (POS_W'(entry.len) >= want_ff);
         SCAN_END:   hit = entry.free && (entry.len != '0) && (e_end == p_off_ff);
         SCAN_PLACE: hit = (entry.len == '0) || (entry.free && (e_end == p_off_ff));
         SCAN_ADDR:  hit = (entry.len != '0) && (rel_ff[ADDR_W-1:OFF_W] == '0)
                           && (entry.off == rel_ff[OFF_W-1:0]);
         SCAN_RIGHT: hit = (idx_ff != c_idx_ff) && entry.free && (entry.len != '0)
                           && (POS_W'(entry.off) == c_end);
         SCAN_LEFT:  hit = entry.free && (entry.len != '0) && (e_end == POS_W'(c_off_ff));
         default:    hit = 1'b0;
      endcase
   end

   // status back to the controller
   always_comb begin
      stat.hit        = hit;
      stat.empty      = (entry.len == '0);
      stat.last       = (CNT_W'(idx_ff) + CNT_W'(1)) >= slots_ff;
      stat.split      = POS_W'(h_len_ff) > want_ff;
      stat.at_limit   = pages_ff >= lim;
      stat.table_full = slots_ff >= CNT_W'(SLOTS);
      stat.hit_is_c   = (idx_ff == c_idx_ff);
      stat.size_zero  = size_zero_ff;
      stat.cmd        = cmd_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // table write port
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff;
      wr_data = '0;
      unique case (cmd_in.op)
         OP_WRITE_ALLOC: begin
            wr_addr = h_idx_ff;
            wr_data = '{free: 1'b0, len: want_ff[LEN_W-1:0], off: h_off_ff};
         end
         OP_GROW_EXTEND: wr_data = '{free: entry.free, len: entry.len + PAGE_LEN,
                                     off: entry.off};
         OP_PLACE_EMPTY: wr_data = '{free: 1'b1, len: p_len_ff, off: p_off_ff[OFF_W-1:0]};
         OP_PLACE_MERGE: wr_data = '{free: entry.free, len: entry.len + p_len_ff,
                                     off: entry.off};
         OP_PLACE_NEW: begin
            wr_addr = slots_ff[IDX_W-1:0];
            wr_data = '{free: 1'b1, len: p_len_ff, off: p_off_ff[OFF_W-1:0]};
         end
         OP_RIGHT_MERGE, OP_LEFT_MERGE: wr_data = '0;
         OP_WRITE_FREE: begin
            wr_addr = c_idx_ff;
            wr_data = '{free: 1'b1, len: c_len_ff, off: c_off_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff      <= CNT_W'(1);
         pages_ff      <= PAGE_W'(1);
         heap_base_ff  <= '0;
         max_pages_ff  <= PAGE_LIMIT;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            slot_valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd_in.op == OP_PLACE_NEW) begin
            slots_ff <= slots_ff + CNT_W'(1);
         end
         if (cmd_in.op == OP_PAGES_INC) begin
            pages_ff <= pages_ff + PAGE_W'(1);
         end
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_HEAP_BASE: heap_base_ff <= csr_data;
               CSR_MAX_PAGES: max_pages_ff <= csr_data[PAGE_W-1:0];
               default: ;
            endcase
         end
         if (cmd_in.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      rd_valid_ff <= slot_valid_ff[idx_ff];
      rd_first_ff <= (idx_ff == '0);
      case (cmd_in.op)
         OP_CAPTURE: begin
            cmd_ff       <= req_data.cmd;
            want_ff      <= want_in;
            size_zero_ff <= (req_data.req_size == '0);
            rel_ff       <= req_data.req_address - heap_base_ff;
         end
         OP_SET_STATUS: res_ff <= '{status: cmd_in.status, chunk_address: '0,
                                    chunk_size: '0};
         OP_SCAN_INIT: idx_ff <= '0;
         OP_SCAN_INC:  idx_ff <= idx_ff + IDX_W'(1);
         OP_HIT_FIT: begin
            h_idx_ff <= idx_ff;
            h_off_ff <= entry.off;
            h_len_ff <= entry.len;
            p_off_ff <= POS_W'(entry.off) + want_ff;
            p_len_ff <= entry.len - want_ff[LEN_W-1:0];
         end
         OP_WRITE_ALLOC: res_ff <= '{status: ST_OK,
                                     chunk_address: heap_base_ff + ADDR_W'(h_off_ff),
                                     chunk_size: want_ff[LEN_W-1:0]};
         OP_GROW_SET: begin
            p_off_ff <= POS_W'(pages_ff) << PAGE_SHIFT;
            p_len_ff <= PAGE_LEN;
         end
         OP_FOUND: begin
            c_idx_ff <= idx_ff;
            c_off_ff <= entry.off;
            c_len_ff <= entry.len;
         end
         OP_RESP_QUERY: res_ff <= '{status: ST_OK, chunk_address: '0,
                                    chunk_size: c_len_ff};
         OP_RIGHT_MERGE: c_len_ff <= c_len_ff + entry.len;
         OP_LEFT_MERGE: begin
            c_off_ff <= entry.off;
            c_len_ff <= c_len_ff + entry.len;
         end
         OP_WRITE_FREE: res_ff <= '{status: ST_OK, chunk_address: '0, chunk_size: '0};
         OP_EMIT: rsp_data_ff <= res_ff;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/fca_ctrl.sv
// controller: sequences the table scans of allocate, free and query
module fca_ctrl
   import fca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd_out
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_EV,
      S_FIT_DONE,
      S_ALLOC_WR,
      S_GROW,
      S_GROW_SCAN,
      S_GROW_FIN,
      S_FIT_RESTART,
      S_QUERY_RESP,
      S_RIGHT_INIT,
      S_LEFT_INIT,
      S_FREE_WR,
      S_DONE
   } state_type;

   state_type     state_ff, state_in;
   scan_kind_type kind_ff, kind_in;
   logic          ret_grow_ff, ret_grow_in;

   // next state and datapath command
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      ret_grow_in    = ret_grow_ff;
      cmd_out.op     = OP_NONE;
      cmd_out.kind   = kind_ff;
      cmd_out.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_out.op = OP_CAPTURE;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (cmd_type'(stat.cmd))
               CMD_ALLOC: begin
                  if (stat.size_zero) begin
                     cmd_out.op     = OP_SET_STATUS;
                     cmd_out.status = ST_ZERO;
                     state_in       = S_DONE;
                  end else begin
                     cmd_out.op = OP_SCAN_INIT;
                     kind_in    = SCAN_FIT;
                     state_in   = S_SCAN_RD;
                  end
               end
               CMD_FREE, CMD_QUERY: begin
                  cmd_out.op = OP_SCAN_INIT;
                  kind_in    = SCAN_ADDR;
                  state_in   = S_SCAN_RD;
               end
               default: begin
                  cmd_out.op     = OP_SET_STATUS;
                  cmd_out.status = ST_NOTFOUND;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            if (!stat.hit && !stat.last) begin
               cmd_out.op = OP_SCAN_INC;
               state_in   = S_SCAN_RD;
            end else begin
               unique case (kind_ff)
                  SCAN_FIT: begin
                     if (stat.hit) begin
                        cmd_out.op = OP_HIT_FIT;
                        state_in   = S_FIT_DONE;
                     end else begin
                        state_in = S_GROW;
                     end
                  end
                  SCAN_END: begin
                     if (stat.hit) begin
                        cmd_out.op = OP_GROW_EXTEND;
                        state_in   = S_GROW_FIN;
                     end else begin
                        cmd_out.op  = OP_SCAN_INIT;
                        kind_in     = SCAN_PLACE;
                        ret_grow_in = 1'b1;
                        state_in    = S_SCAN_RD;
                     end
                  end
                  SCAN_PLACE: begin
                     if (stat.hit || !stat.table_full) begin
                        if (!stat.hit) begin
                           cmd_out.op = OP_PLACE_NEW;
                        end else if (stat.empty) begin
                           cmd_out.op = OP_PLACE_EMPTY;
                        end else begin
                           cmd_out.op = OP_PLACE_MERGE;
                        end
                        state_in = ret_grow_ff ? S_GROW_FIN : S_ALLOC_WR;
                     end else begin
                        cmd_out.op     = OP_SET_STATUS;
                        cmd_out.status = ST_NOMEM;
                        state_in       = S_DONE;
                     end
                  end
                  SCAN_ADDR: begin
                     if (stat.hit) begin
                        cmd_out.op = OP_FOUND;
                        state_in   = (stat.cmd == CMD_QUERY) ? S_QUERY_RESP : S_RIGHT_INIT;
                     end else begin
                        cmd_out.op     = OP_SET_STATUS;
                        cmd_out.status = ST_NOTFOUND;
                        state_in       = S_DONE;
                     end
                  end
                  SCAN_RIGHT: begin
                     if (stat.hit) begin
                        cmd_out.op = OP_RIGHT_MERGE;
                     end
                     state_in = S_LEFT_INIT;
                  end
                  default: begin
                     if (stat.hit && !stat.hit_is_c) begin
                        cmd_out.op = OP_LEFT_MERGE;
                     end
                     state_in = S_FREE_WR;
                  end
               endcase
            end
         end
         S_FIT_DONE: begin
            if (stat.split) begin
               cmd_out.op  = OP_SCAN_INIT;
               kind_in     = SCAN_PLACE;
               ret_grow_in = 1'b0;
               state_in    = S_SCAN_RD;
            end else begin
               state_in = S_ALLOC_WR;
            end
         end
         S_ALLOC_WR: begin
            cmd_out.op = OP_WRITE_ALLOC;
            state_in   = S_DONE;
         end
         S_GROW: begin
            if (stat.at_limit) begin
               cmd_out.op     = OP_SET_STATUS;
               cmd_out.status = ST_NOMEM;
               state_in       = S_DONE;
            end else begin
               cmd_out.op = OP_GROW_SET;
               state_in   = S_GROW_SCAN;
            end
         end
         S_GROW_SCAN: begin
            cmd_out.op = OP_SCAN_INIT;
            kind_in    = SCAN_END;
            state_in   = S_SCAN_RD;
         end
         S_GROW_FIN: begin
            cmd_out.op = OP_PAGES_INC;
            state_in   = S_FIT_RESTART;
         end
         S_FIT_RESTART: begin
            cmd_out.op = OP_SCAN_INIT;
            kind_in    = SCAN_FIT;
            state_in   = S_SCAN_RD;
         end
         S_QUERY_RESP: begin
            cmd_out.op = OP_RESP_QUERY;
            state_in   = S_DONE;
         end
         S_RIGHT_INIT: begin
            cmd_out.op = OP_SCAN_INIT;
            kind_in    = SCAN_RIGHT;
            state_in   = S_SCAN_RD;
         end
         S_LEFT_INIT: begin
            cmd_out.op = OP_SCAN_INIT;
            kind_in    = SCAN_LEFT;
            state_in   = S_SCAN_RD;
         end
         S_FREE_WR: begin
            cmd_out.op = OP_WRITE_FREE;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd_out.op = OP_EMIT;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         kind_ff     <= SCAN_FIT;
         ret_grow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         ret_grow_ff <= ret_grow_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: src/first_fit_chunk_allocator_top.sv
// top level of the first-fit chunk allocator
// The block takes one request word at a time (allocate, free or query) and answers each
// with one response word. Work on a request walks the 64-entry slot table through one
// ram read port, up to the last slot in use: a query is one pass, a free three passes,
// an allocate one fit pass plus a placement pass when the chunk is split, and each page
// of heap growth adds up to two more passes and a new fit pass. The response sits in an
// output register, so a new request word is taken while the last response still waits.
// Config words are taken at any time and should be written only while the block is idle;
// the table needs no clearing after reset.
module first_fit_chunk_allocator_top
   import fca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer
   fca_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (dp_stat),
      .cmd_out  (dp_cmd)
   );

   // table and arithmetic
   fca_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd_in   (dp_cmd),
      .req_data (req_data),
      .stat     (dp_stat),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   assign csr_ready = 1'b1;

endmodule

// File: tb/first_fit_chunk_allocator_checker.sv
// response checker and allocator predictor for the first-fit chunk allocator testbench
`timescale 1ns / 100ps

module first_fit_chunk_allocator_checker
   import fca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_word_type      req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_word_type      rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_data,
   output int                fail_count,
   output int                words_pending,
   output int                words_checked
);

   // predicted allocator state
   logic [OFF_W-1:0]  chunk_off [SLOTS];
   logic [LEN_W-1:0]  chunk_len [SLOTS];
   logic              chunk_free [SLOTS];
   int unsigned       slots_seen;
   int unsigned       heap_pages;
   logic [ADDR_W-1:0] base_addr;
   logic [PAGE_W-1:0] page_limit;

   rsp_word_type expected_rsp [$];

   assign words_pending = expected_rsp.size();

   function automatic int unsigned table_span();
      return (slots_seen > SLOTS) ? SLOTS : slots_seen;
   endfunction

   // free chunk whose end lands on the given offset
   function automatic int free_ending_at(int unsigned end_pos);
      for (int i = 0; i < table_span(); i++)
         if (chunk_free[i] && chunk_len[i] != 0 &&
             int'(chunk_off[i]) + int'(chunk_len[i]) == end_pos)
            return i;
      return -1;
   endfunction

   function automatic int chunk_at(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] rel;
      rel = addr - base_addr;
      for (int i = 0; i < table_span(); i++)
         if (chunk_len[i] != 0 && ADDR_W'(chunk_off[i]) == rel)
            return i;
      return -1;
   endfunction

   // record a free piece: empty slot, left merge or fresh slot, first in table order
   function automatic bit put_free_piece(int unsigned off, int unsigned len);
      int unsigned n;
      n = table_span();
      for (int i = 0; i < n; i++) begin
         if (chunk_len[i] == 0) begin
            chunk_off[i]  = off[OFF_W-1:0];
            chunk_len[i]  = len[LEN_W-1:0];
            chunk_free[i] = 1'b1;
            return 1'b1;
         end
         if (chunk_free[i] && int'(chunk_off[i]) + int'(chunk_len[i]) == off) begin
            chunk_len[i] = chunk_len[i] + len[LEN_W-1:0];
            return 1'b1;
         end
      end
      if (n >= SLOTS)
         return 1'b0;
      chunk_off[n]  = off[OFF_W-1:0];
      chunk_len[n]  = len[LEN_W-1:0];
      chunk_free[n] = 1'b1;
      slots_seen    = n + 1;
      return 1'b1;
   endfunction

   function automatic bit add_page();
      int unsigned cap;
      int j;
      cap = (page_limit > HEAP_PAGES) ? HEAP_PAGES : page_limit;
      if (heap_pages >= cap)
         return 1'b0;
      j = free_ending_at(heap_pages * 4096);
      if (j >= 0)
         chunk_len[j] = chunk_len[j] + PAGE_LEN;
      else if (!put_free_piece(heap_pages * 4096, 4096))
         return 1'b0;
      heap_pages++;
      return 1'b1;
   endfunction

   function automatic int first_fit(int unsigned want);
      for (int i = 0; i < table_span(); i++)
         if (chunk_free[i] && chunk_len[i] != 0 && int'(chunk_len[i]) >= want)
            return i;
      return -1;
   endfunction

   function automatic rsp_word_type allocator_result(req_word_type r);
      rsp_word_type o;
      int unsigned want;
      int hit;
      int c;
      int l;
      o = '0;
      o.status = ST_OK;
      case (r.cmd)
         CMD_ALLOC: begin
            if (r.req_size == 0) begin
               o.status = ST_ZERO;
               return o;
            end
            want = (int'(r.req_size) + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
            hit = first_fit(want);
            while (hit < 0) begin
               if (!add_page()) begin
                  o.status = ST_NOMEM;
                  return o;
               end
               hit = first_fit(want);
            end
            if (int'(chunk_len[hit]) > want &&
                !put_free_piece(int'(chunk_off[hit]) + want, int'(chunk_len[hit]) - want)) begin
               o.status = ST_NOMEM;
               return o;
            end
            chunk_len[hit]  = want[LEN_W-1:0];
            chunk_free[hit] = 1'b0;
            o.chunk_address = base_addr + ADDR_W'(chunk_off[hit]);
            o.chunk_size    = want[LEN_W-1:0];
         end
         CMD_FREE: begin
            c = chunk_at(r.req_address);
            if (c < 0) begin
               o.status = ST_NOTFOUND;
               return o;
            end
            chunk_free[c] = 1'b1;
            // right neighbor first
            for (int i = 0; i < table_span(); i++)
               if (i != c && chunk_free[i] && chunk_len[i] != 0 &&
                   int'(chunk_off[i]) == int'(chunk_off[c]) + int'(chunk_len[c])) begin
                  chunk_len[c]  = chunk_len[c] + chunk_len[i];
                  chunk_off[i]  = '0;
                  chunk_len[i]  = '0;
                  chunk_free[i] = 1'b0;
                  break;
               end
            // then left neighbor
            l = free_ending_at(chunk_off[c]);
            if (l >= 0 && l != c) begin
               chunk_off[c]  = chunk_off[l];
               chunk_len[c]  = chunk_len[c] + chunk_len[l];
               chunk_off[l]  = '0;
               chunk_len[l]  = '0;
               chunk_free[l] = 1'b0;
            end
         end
         CMD_QUERY: begin
            c = chunk_at(r.req_address);
            if (c < 0)
               o.status = ST_NOTFOUND;
            else
               o.chunk_size = chunk_len[c];
         end
         default: o.status = ST_NOTFOUND;
      endcase
      return o;
   endfunction

   // track config, predict each accepted request word, check each response word
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            chunk_off[i]  = '0;
            chunk_len[i]  = '0;
            chunk_free[i] = 1'b0;
         end
         chunk_len[0]  = PAGE_LEN;
         chunk_free[0] = 1'b1;
         slots_seen    = 1;
         heap_pages    = 1;
         base_addr     = '0;
         page_limit    = PAGE_W'(256);
         fail_count    <= 0;
         words_checked <= 0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEAP_BASE)
               base_addr = csr_data;
            else
               page_limit = csr_data[PAGE_W-1:0];
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(allocator_result(req_data));
         if (rsp_valid && rsp_ready) begin
            words_checked <= words_checked + 1;
            if (expected_rsp.size() == 0) begin
               $error("response word with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_word = expected_rsp.pop_front();
               if (rsp_data.status !== exp_word.status ||
                   rsp_data.chunk_address !== exp_word.chunk_address ||
                   rsp_data.chunk_size !== exp_word.chunk_size)
                  fail_count <= fail_count + 1;
               if (rsp_data.status !== exp_word.status)
                  $error("status expected %0d got %0d", exp_word.status, rsp_data.status);
               if (rsp_data.chunk_address !== exp_word.chunk_address)
                  $error("chunk_address expected %h got %h",
                         exp_word.chunk_address, rsp_data.chunk_address);
               if (rsp_data.chunk_size !== exp_word.chunk_size)
                  $error("chunk_size expected %0d got %0d",
                         exp_word.chunk_size, rsp_data.chunk_size);
            end
         end
      end
   end

endmodule

// File: tb/first_fit_chunk_allocator_top_tb.sv
// testbench top: stimulus, handshake pacing and verdict for the chunk allocator
`timescale 1ns / 100ps

module first_fit_chunk_allocator_top_tb;
   import fca_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_word_type      req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_word_type      rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [ADDR_W-1:0] csr_data = '0;

   int fail_count;
   int words_pending;
   int words_checked;
   int cycle_count = 0;
   int burst_left = 0;
   int n_alloc = 0, n_free = 0, n_query = 0, n_bad = 0, n_settings = 0;

   logic [ADDR_W-1:0] cur_base = '0;
   // offsets of chunks handed out and of chunks already freed
   int unsigned live_off [$];
   int unsigned dead_off [$];
   // commands and bases of words still waiting for a response
   cmd_type           sent_cmd [$];
   logic [ADDR_W-1:0] sent_base [$];

   always #4 clock = ~clock;

   first_fit_chunk_allocator_top DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   first_fit_chunk_allocator_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .words_pending, .words_checked
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // remember which allocations succeeded, for later frees and queries
   always @(posedge clock) begin
      cmd_type c;
      logic [ADDR_W-1:0] b;
      if (!reset && rsp_valid && rsp_ready && sent_cmd.size() != 0) begin
         c = sent_cmd.pop_front();
         b = sent_base.pop_front();
         if (c == CMD_ALLOC && rsp_data.status == ST_OK)
            live_off.push_back(int'(rsp_data.chunk_address - b));
      end
   end

   // receiver stalls: one of four ready modes, picked from the cycle count
   always @(negedge clock) begin
      int mode;
      mode = (cycle_count / 64) % 4;
      case (mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 9) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // send one request word, keeping valid high inside a burst
   task automatic send_word(cmd_type c, int unsigned sz, logic [ADDR_W-1:0] addr);
      req_data.cmd         <= c;
      req_data.req_size    <= sz[LEN_W-1:0];
      req_data.req_address <= addr;
      req_valid            <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_cmd.push_back(c);
      sent_base.push_back(cur_base);
      case (c)
         CMD_ALLOC: n_alloc++;
         CMD_FREE:  n_free++;
         CMD_QUERY: n_query++;
         default:   n_bad++;
      endcase
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 3))
            @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
   endtask

   // sender holds off until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [ADDR_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_HEAP_BASE)
         cur_base = val;
   endtask

   task automatic random_word();
      int unsigned pick;
      int unsigned k;
      int unsigned sz;
      logic [ADDR_W-1:0] noise;
      pick  = $urandom_range(0, 99);
      noise = {$urandom, $urandom};
      if (pick < 48) begin
         k = $urandom_range(0, 19);
         if (k < 14)      sz = $urandom_range(1, 512);
         else if (k < 18) sz = $urandom_range(513, 8192);
         else if (k < 19) sz = $urandom_range(1, 32) * 32;
         else             sz = $urandom & 21'h1FFFFF;
         send_word(CMD_ALLOC, sz, noise);
      end else if (pick < 78 && live_off.size() != 0) begin
         k = $urandom_range(0, live_off.size() - 1);
         dead_off.push_back(live_off[k]);
         send_word(CMD_FREE, $urandom, cur_base + ADDR_W'(live_off[k]));
         live_off.delete(k);
      end else if (pick < 88 && live_off.size() != 0) begin
         k = $urandom_range(0, live_off.size() - 1);
         send_word(CMD_QUERY, $urandom, cur_base + ADDR_W'(live_off[k]));
      end else if (pick < 92 && dead_off.size() != 0) begin
         k = $urandom_range(0, dead_off.size() - 1);
         send_word($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY, $urandom,
                   cur_base + ADDR_W'(dead_off[k]));
      end else if (pick < 95) begin
         send_word(CMD_ALLOC, 0, noise);
      end else if (pick < 97) begin
         send_word(CMD_BAD, $urandom, noise);
      end else begin
         send_word($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY, $urandom, noise);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fresh heap, so the first chunks land at offsets 0, 32 and 64
      send_word(CMD_ALLOC, 1, '0);
      send_word(CMD_ALLOC, 32, '0);
      send_word(CMD_ALLOC, 33, '1);
      send_word(CMD_ALLOC, 0, '0);
      send_word(CMD_ALLOC, 4096, '0);
      send_word(CMD_QUERY, 0, 48'd32);
      send_word(CMD_QUERY, 0, 48'd64);
      send_word(CMD_FREE, 0, 48'd32);
      send_word(CMD_FREE, 0, 48'd32);
      send_word(CMD_FREE, 21'h1FFFFF, 48'd0);
      send_word(CMD_QUERY, 0, 48'd0);
      send_word(CMD_QUERY, 0, 48'd33);
      send_word(CMD_FREE, 0, '1);
      send_word(CMD_BAD, 21'h1FFFFF, '1);
      send_word(CMD_ALLOC, 2097151, '0);
      send_word(CMD_ALLOC, 1048576, '0);
      send_word(CMD_ALLOC, 31, '0);
      send_word(CMD_FREE, 0, 48'd64);
      drain();

      // register settings, extremes included, each followed by random traffic
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_HEAP_BASE, 48'h0000_1234_5600); write_reg(CSR_MAX_PAGES, 256); end
            1: write_reg(CSR_MAX_PAGES, 1);
            2: begin write_reg(CSR_HEAP_BASE, '1); write_reg(CSR_MAX_PAGES, 0); end
            3: begin write_reg(CSR_HEAP_BASE, 48'hA5A5_5A5A_0000); write_reg(CSR_MAX_PAGES, 8); end
            4: write_reg(CSR_MAX_PAGES, 511);
            default: begin write_reg(CSR_HEAP_BASE, '0); write_reg(CSR_MAX_PAGES, 256); end
         endcase
         n_settings++;
         repeat (172) random_word();
         drain();
      end

      while (words_pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d allocate, %0d free, %0d query and %0d bad-command words",
               n_alloc, n_free, n_query, n_bad);
      $display("checked %0d response words over %0d register settings",
               words_checked, n_settings + 1);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
